@@ rtl/core/hpt_pkg.sv @@
// Shared constants and types for the homogeneous point transform.
package hpt_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_COEF      = 16;
  localparam int unsigned QUO_BITS      = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef struct packed {
    logic [2:0][63:0] rem;
    logic [2:0][31:0] nlo;
    logic [2:0][31:0] quo;
    logic [2:0]       neg;
    logic [2:0]       ovf;
    logic             zero;
    logic [63:0]      dmag;
  } div_t;

endpackage

@@ rtl/core/hpt_if.sv @@
// Valid/ready channel interfaces for the point transform input and result words.
interface hpt_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [3:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, opcode, coef_index, coef_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, point_x, point_y, point_z,
                  output ready);
endinterface

interface hpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               zero_divisor;
  logic               saturated;

  modport source (output valid, out_x, out_y, out_z, zero_divisor, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, zero_divisor, saturated, output ready);
endinterface

@@ rtl/core/homogeneous_point_transform.sv @@
// Pipelined 4x4 matrix point transform with perspective divide.
//
// Input channel in_i carries load and transform words. A load word (opcode 0)
// writes one column-major Q coefficient into the matrix and gives no result.
// A transform word (opcode 1) takes x, y, z with w = 1 and gives one result
// word on out_o: x', y', z' divided by the w row sum, truncated toward zero
// and saturated, plus zero_divisor and saturated flags.
// Throughput: one word per cycle while the receiver does not stall. A transform
// word passes through one multiply stage, one row sum stage, two setup stages,
// 32 restoring divide stages (one quotient bit each, three rows in parallel)
// and the output register.
// Each stage holds its own valid bit; a stage advances when it is empty or
// its successor advances, so bubbles collapse and a stalled receiver fills
// the pipeline before in_i.ready drops. Nothing is lost or repeated.
// Reset clears all valid bits and returns the matrix to identity.
module homogeneous_point_transform
  import hpt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hpt_in_if.sink     in_i,
  hpt_out_if.source  out_o
);

  localparam int unsigned NSTG = 5 + QUO_BITS;
  localparam int unsigned NW   = 64 + FRAC_BITS;
  localparam logic [31:0] ONE  = 32'(1) << FRAC_BITS;

  logic [31:0] mat_q [NUM_COEF];
  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic signed [63:0] prod_q [4][4];
  logic signed [65:0] sum_q  [4];
  logic [63:0]        mag_q  [4];
  logic [3:0]         sgn_q;
  div_t               div_q  [QUO_BITS+1];
  div_t               div_d  [QUO_BITS+1];

  logic signed [31:0] ox_q, oy_q, oz_q;
  logic               zd_q, sat_q;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        mat_q[i] <= (i % 5 == 0) ? ONE : 32'd0;
      end
    end else begin
      if (in_i.valid && en[0] && in_i.opcode == OP_LOAD) begin
        mat_q[in_i.coef_index] <= in_i.coef_value;
      end
      if (en[0]) begin
        v_q[0] <= in_i.valid && in_i.opcode == OP_XFORM;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int r = 0; r < 4; r++) begin
        prod_q[r][0] <= $signed(mat_q[r]) * in_i.point_x;
        prod_q[r][1] <= $signed(mat_q[4+r]) * in_i.point_y;
        prod_q[r][2] <= $signed(mat_q[8+r]) * in_i.point_z;
        prod_q[r][3] <= 64'($signed(mat_q[12+r])) <<< FRAC_BITS;
      end
    end
    if (en[1]) begin
      for (int r = 0; r < 4; r++) begin
        sum_q[r] <= 66'(prod_q[r][0]) + 66'(prod_q[r][1])
                  + 66'(prod_q[r][2]) + 66'(prod_q[r][3]);
      end
    end
    if (en[2]) begin
      for (int r = 0; r < 4; r++) begin
        sgn_q[r] <= sum_q[r][65];
        mag_q[r] <= sum_q[r][65] ? 64'(-sum_q[r]) : sum_q[r][63:0];
      end
    end
  end

  always_comb begin
    logic [NW-1:0] nw;
    div_d[0] = div_q[0];
    div_d[0].dmag = mag_q[3];
    div_d[0].zero = (mag_q[3] == 64'd0);
    for (int i = 0; i < 3; i++) begin
      nw = {mag_q[i], {FRAC_BITS{1'b0}}};
      div_d[0].rem[i] = 64'(nw[NW-1:32]);
      div_d[0].nlo[i] = nw[31:0];
      div_d[0].quo[i] = '0;
      div_d[0].neg[i] = sgn_q[i] ^ sgn_q[3];
      div_d[0].ovf[i] = 64'(nw[NW-1:32]) >= mag_q[3];
    end
  end

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    always_comb begin
      logic [64:0] r2;
      logic        ge;
      div_d[j+1] = div_q[j];
      for (int i = 0; i < 3; i++) begin
        r2 = {div_q[j].rem[i], div_q[j].nlo[i][31]};
        ge = r2 >= {1'b0, div_q[j].dmag};
        div_d[j+1].rem[i] = ge ? 64'(r2 - {1'b0, div_q[j].dmag}) : r2[63:0];
        div_d[j+1].nlo[i] = {div_q[j].nlo[i][30:0], 1'b0};
        div_d[j+1].quo[i] = {div_q[j].quo[i][30:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= QUO_BITS; j++) begin
      if (en[3+j]) begin
        div_q[j] <= div_d[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] lim;
    logic [31:0] mag;
    logic [31:0] res [3];
    logic        sat;
    if (en[NSTG-1]) begin
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        lim = div_q[QUO_BITS].neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
        if (div_q[QUO_BITS].ovf[i] || div_q[QUO_BITS].quo[i] > lim) begin
          sat = 1'b1;
          mag = lim;
        end else begin
          mag = div_q[QUO_BITS].quo[i];
        end
        res[i] = div_q[QUO_BITS].neg[i] ? 32'(-mag) : mag;
      end
      if (div_q[QUO_BITS].zero) begin
        ox_q  <= '0;
        oy_q  <= '0;
        oz_q  <= '0;
        zd_q  <= 1'b1;
        sat_q <= 1'b0;
      end else begin
        ox_q  <= res[0];
        oy_q  <= res[1];
        oz_q  <= res[2];
        zd_q  <= 1'b0;
        sat_q <= sat;
      end
    end
  end

  assign out_o.valid        = v_q[NSTG-1];
  assign out_o.out_x        = ox_q;
  assign out_o.out_y        = oy_q;
  assign out_o.out_z        = oz_q;
  assign out_o.zero_divisor = zd_q;
  assign out_o.saturated    = sat_q;

  a_load_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.opcode == OP_LOAD |=> !v_q[0])
    else $error("load word entered the pipeline");

  a_zero_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_divisor |->
      out_o.out_x == 0 && out_o.out_y == 0 && out_o.out_z == 0 && !out_o.saturated)
    else $error("zero divisor result not cleared");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NSTG-2] && !en[NSTG-2] |=> v_q[NSTG-2] && v_q[NSTG-1])
    else $error("stalled word dropped");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> v_q == {NSTG{1'b1}})
    else $error("input stalled with a free stage");

endmodule
